@@ rtl/core/itf_pkg.sv @@
// Shared types, constants and helper functions of the integer-to-text formatter.
// Used by the input channel interface, the controller, the datapath and the top level.
package itf_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_CHARS  = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Width of the requested field width on the input channel.
  localparam int FIELD_WIDTH_W = 6;

  // ASCII codes used for padding and sign.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Conversion modes.
  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_LHEX = 2'd2,
    MODE_UHEX = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_DIGITS,
    ST_SIZE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic dabble;
    logic push;
    logic sizing;
    logic emit;
  } itf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_dec;
    logic dabble_last;
    logic digits_last;
    logic emit_last;
    logic out_free;
  } itf_status_t;

  // ASCII character of one digit value, upper or lower case for hex letters.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CH_UPPER_A + {4'd0, d - 4'd10};
    end else begin
      ch = CH_LOWER_A + {4'd0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/itf_in_if.sv @@
// Input channel of the formatter: valid/ready handshake with the number and its format.
// Depends on itf_pkg for the mode type and the field width size.
interface itf_in_if #(
  parameter int VALUE_BITS = itf_pkg::DEF_VALUE_BITS
) ();
  logic                                valid;
  logic                                ready;
  logic [VALUE_BITS-1:0]               value;
  itf_pkg::mode_t                      mode;
  logic [itf_pkg::FIELD_WIDTH_W-1:0]   field_width;
  logic                                zero_pad;

  modport source (output valid, value, mode, field_width, zero_pad, input ready);
  modport sink   (input valid, value, mode, field_width, zero_pad, output ready);
endinterface

@@ rtl/core/itf_out_if.sv @@
// Result channel of the formatter: valid/ready handshake with one character per transfer.
// Stands alone; no package types are needed.
interface itf_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

@@ rtl/core/integer_to_text_formatter_top.sv @@
// Integer-to-text formatter top level: controller and datapath behind two stream channels.
// An item runs from acceptance through the binary-to-BCD steps (decimal modes only, one per
// value bit, none for hex), the digit pushes onto the digit stack, a sizing step and the
// character emits, which stall while the output is held; then the next item can be accepted.
// Reset (rst_n, synchronous, active low) returns the controller to idle and empties the
// output register; no clearing pass.
module integer_to_text_formatter_top #(
  parameter int MAX_CHARS  = itf_pkg::DEF_MAX_CHARS,
  parameter int VALUE_BITS = itf_pkg::DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  itf_in_if.sink    in_ch,
  itf_out_if.source out_ch
);
  import itf_pkg::*;

  itf_cmd_t    cmd;
  itf_status_t status;
  state_t      fsm_state;

  // Sequencing of one item.
  itf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .fsm_state (fsm_state)
  );

  // Conversion and character output.
  itf_dp #(
    .MAX_CHARS  (MAX_CHARS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_ch.value),
    .in_mode        (in_ch.mode),
    .in_field_width (in_ch.field_width),
    .in_zero_pad    (in_ch.zero_pad),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_character  (out_ch.character),
    .out_last       (out_ch.last)
  );

  // An accepted item keeps the controller busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (fsm_state != ST_IDLE))
    else $error("controller idle right after an input transfer");

  // A character that is not the final one waits only while its item is still emitting.
  a_nonlast_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (fsm_state != ST_IDLE))
    else $error("non-final character pending while the controller is idle");

  // Emitting the final position loads a valid character marked last.
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.emit_last) |=> (out_ch.valid && out_ch.last))
    else $error("final character not marked last");

endmodule

@@ rtl/core/itf_ctrl.sv @@
// Controller state machine of the formatter: sequences load, conversion, sizing and output.
// Depends on itf_pkg for the state, command and status types.
module itf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itf_pkg::itf_status_t status,
  output itf_pkg::itf_cmd_t    cmd,
  output itf_pkg::state_t      fsm_state
);
  import itf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.in_dec ? ST_DABBLE : ST_DIGITS;
        end
      end
      ST_DABBLE: begin
        if (status.dabble_last) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (status.digits_last) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
      end
      ST_DIGITS: begin
        cmd.push = 1'b1;
      end
      ST_SIZE: begin
        cmd.sizing = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign fsm_state = state_r;

endmodule

@@ rtl/core/itf_dp.sv @@
// Datapath of the formatter: BCD converter, digit stack, field sizing and output register.
// Depends on itf_pkg for command/status types, modes, ASCII codes and digit_char.
module itf_dp #(
  parameter int MAX_CHARS  = itf_pkg::DEF_MAX_CHARS,
  parameter int VALUE_BITS = itf_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [VALUE_BITS-1:0]             in_value,
  input  itf_pkg::mode_t                    in_mode,
  input  logic [itf_pkg::FIELD_WIDTH_W-1:0] in_field_width,
  input  logic                              in_zero_pad,
  input  itf_pkg::itf_cmd_t                 cmd,
  output itf_pkg::itf_status_t              status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [7:0]                        out_character,
  output logic                              out_last
);
  import itf_pkg::*;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DW         = 4 * NDIG;
  localparam int SD         = (MAX_CHARS < NDIG) ? MAX_CHARS : NDIG;
  localparam int CW         = $clog2(MAX_CHARS + 1);
  localparam int BW         = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_CHARS);
  localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_BITS - 1);

  // Item attributes.
  logic          neg_r,    neg_nxt;
  logic          zpad_r,   zpad_nxt;
  logic          upper_r,  upper_nxt;
  logic [CW-1:0] width_r,  width_nxt;

  // Conversion state.
  logic [VALUE_BITS-1:0] bin_r,    bin_nxt;
  logic [DW-1:0]         digits_r, digits_nxt;
  logic [BW-1:0]         bitcnt_r, bitcnt_nxt;
  logic [3:0]            stack_r   [SD];
  logic [3:0]            stack_nxt [SD];
  logic [CW-1:0]         cnt_r,    cnt_nxt;

  // Output sequencing.
  logic [CW-1:0] pos_r,      pos_nxt;
  logic [CW-1:0] sign_pos_r, sign_pos_nxt;
  logic          sign_en_r,  sign_en_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r,  out_char_nxt;
  logic       out_last_r,  out_last_nxt;

  // Helper values.
  logic [VALUE_BITS-1:0] mag;
  logic                  in_neg;
  logic [DW-1:0]         adj;
  logic [CW-1:0]         wm1, mz, ms, n_chars, sp;
  logic                  out_free;

  assign in_neg   = (in_mode == MODE_SDEC) && in_value[VALUE_BITS-1];
  assign mag      = in_neg ? ('0 - in_value) : in_value;
  assign out_free = !out_valid_r || out_ready;

  // Add-3 correction of every BCD digit before the next shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (digits_r[4*i +: 4] >= 4'd5) ? digits_r[4*i +: 4] + 4'd3
                                                   : digits_r[4*i +: 4];
    end
  end

  // Field sizing: total character count and where the minus sign lands.
  always_comb begin
    wm1 = (width_r == '0) ? '0 : width_r - CW'(1);
    mz  = (cnt_r > wm1) ? cnt_r : wm1;
    ms  = (cnt_r < MAX_C) ? cnt_r + CW'(1) : MAX_C;
    if (neg_r && zpad_r) begin
      n_chars = (mz < MAX_C) ? mz + CW'(1) : MAX_C;
      sp      = mz;
    end else if (neg_r) begin
      n_chars = (ms > width_r) ? ms : width_r;
      sp      = cnt_r;
    end else begin
      n_chars = (cnt_r > width_r) ? cnt_r : width_r;
      sp      = cnt_r;
    end
  end

  // Next values of the datapath registers.
  always_comb begin
    neg_nxt       = neg_r;
    zpad_nxt      = zpad_r;
    upper_nxt     = upper_r;
    width_nxt     = width_r;
    bin_nxt       = bin_r;
    digits_nxt    = digits_r;
    bitcnt_nxt    = bitcnt_r;
    stack_nxt     = stack_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    sign_pos_nxt  = sign_pos_r;
    sign_en_nxt   = sign_en_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cmd.load) begin
      // Take the magnitude and the format of a new item.
      neg_nxt    = in_neg;
      zpad_nxt   = in_zero_pad;
      upper_nxt  = (in_mode == MODE_UHEX);
      width_nxt  = (int'(in_field_width) > MAX_CHARS) ? MAX_C : CW'(in_field_width);
      bin_nxt    = mag;
      bitcnt_nxt = '0;
      cnt_nxt    = '0;
      digits_nxt = status.in_dec ? '0 : DW'(mag);
    end else if (cmd.dabble) begin
      // One binary-to-BCD step: shift the next bit in after correction.
      digits_nxt = {adj[DW-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt    = {bin_r[VALUE_BITS-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r + BW'(1);
    end else if (cmd.push) begin
      // Push the least significant digit onto the stack while there is room.
      digits_nxt = digits_r >> 4;
      if (cnt_r < MAX_C) begin
        stack_nxt[0] = digits_r[3:0];
        for (int i = 1; i < SD; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
        cnt_nxt = cnt_r + CW'(1);
      end
    end else if (cmd.sizing) begin
      pos_nxt      = n_chars - CW'(1);
      sign_pos_nxt = sp;
      sign_en_nxt  = neg_r && (sp < MAX_C);
    end else if (cmd.emit) begin
      // Produce the character at the current position, most significant first.
      if (pos_r < cnt_r) begin
        out_char_nxt = digit_char(stack_r[0], upper_r);
        for (int i = 0; i < SD - 1; i++) begin
          stack_nxt[i] = stack_r[i+1];
        end
      end else if (sign_en_r && (pos_r == sign_pos_r)) begin
        out_char_nxt = CH_MINUS;
      end else begin
        out_char_nxt = zpad_r ? CH_ZERO : CH_SPACE;
      end
      out_last_nxt  = (pos_r == '0);
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_r - CW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    zpad_r     <= zpad_nxt;
    upper_r    <= upper_nxt;
    width_r    <= width_nxt;
    bin_r      <= bin_nxt;
    digits_r   <= digits_nxt;
    bitcnt_r   <= bitcnt_nxt;
    stack_r    <= stack_nxt;
    pos_r      <= pos_nxt;
    sign_pos_r <= sign_pos_nxt;
    sign_en_r  <= sign_en_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Status to the controller.
  always_comb begin
    status.in_dec      = (in_mode inside {MODE_SDEC, MODE_UDEC});
    status.dabble_last = (bitcnt_r == LAST_BIT);
    status.digits_last = (digits_r[DW-1:4] == '0);
    status.emit_last   = (pos_r == '0);
    status.out_free    = out_free;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
